@@ sv/balance_pid_with_cutoff_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the balance PID block.
// Checks run on clk and are held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BALANCE_PID_WITH_CUTOFF_UNIT_DEFINES_SVH
`define BALANCE_PID_WITH_CUTOFF_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property holds at every edge
`define BPC_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("bpc check failed");

// same-cycle implication
`define BPC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bpc check failed");

// next-cycle implication
`define BPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bpc check failed");

`else

`define BPC_ASSERT_ALWAYS(lbl, expr)
`define BPC_ASSERT_IMP(lbl, ante, cons)
`define BPC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ sv/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, codes and the controller-to-datapath command word.
// ----------------------------------------------------------------------------
package bpc_pkg;

	// fixed point: angles and outputs carry this many fraction bits
	localparam int FRAC_BITS = 7;

	// port widths
	localparam int TILT_W = 16;
	localparam int SP_W   = 14;
	localparam int GAIN_W = 16;
	localparam int OUT_W  = 15;
	localparam int DIR_W  = 2;
	localparam int DUTY_W = 7;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_SETPOINT = 2'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_P   = 2'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_I   = 2'd2;
	localparam logic [IDX_W-1:0] REG_GAIN_D   = 2'd3;

	// reset values of the gains (Q8.8)
	localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd1792;
	localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd77;
	localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd13;

	// shared multiplier operand selection
	localparam logic [1:0] MUL_ADJ = 2'd0;
	localparam logic [1:0] MUL_I   = 2'd1;
	localparam logic [1:0] MUL_P   = 2'd2;
	localparam logic [1:0] MUL_D   = 2'd3;

	// motor direction codes
	localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
	localparam logic [DIR_W-1:0] DIR_NEG  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_POS  = 2'd2;

	// command word from the sequencer
	typedef struct packed {
		logic       load;      // capture the input word
		logic       err_init;  // err = tilt - setpoint
		logic       err_adj;   // add output feedback term to err
		logic       mul_en;    // register a new product
		logic [1:0] mul_sel;   // operand pair for the product
		logic       integ_en;  // update clamped integral
		logic       acc_en;    // P term plus integral
		logic       finish;    // commit state and result
	} bpc_cmd_t;

endpackage

@@ sv/bpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpc_ctrl
// Sequencer: steps one sample through the shared multiplier and owns the
// handshakes on both channels.
// ----------------------------------------------------------------------------
module bpc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output bpc_pkg::bpc_cmd_t cmd
);
	import bpc_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ERR   = 3'd1;
	localparam logic [2:0] S_ADJ   = 3'd2;
	localparam logic [2:0] S_MUL_I = 3'd3;
	localparam logic [2:0] S_INT   = 3'd4;
	localparam logic [2:0] S_ACC   = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	// result register may be reloaded when empty or being taken
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_ERR;
				end
			end
			S_ERR: begin
				cmd.err_init = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_ADJ;
				state_d      = S_ADJ;
			end
			S_ADJ: begin
				cmd.err_adj = 1'b1;
				state_d     = S_MUL_I;
			end
			S_MUL_I: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_I;
				state_d     = S_INT;
			end
			S_INT: begin
				cmd.integ_en = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_P;
				state_d      = S_ACC;
			end
			S_ACC: begin
				cmd.acc_en  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_D;
				state_d     = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ sv/bpc_dp.sv @@
// ----------------------------------------------------------------------------
// bpc_dp
// Datapath: configuration registers, controller state, one shared
// multiplier and the clamp / dead band / drive logic.
// ----------------------------------------------------------------------------
`include "balance_pid_with_cutoff_unit_defines.svh"

module bpc_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bpc_pkg::bpc_cmd_t                      cmd,
	input  logic                                   cfg_we,
	input  logic [bpc_pkg::IDX_W-1:0]              cfg_idx,
	input  logic [bpc_pkg::CFG_W-1:0]              cfg_wdata,
	input  logic signed [bpc_pkg::TILT_W-1:0]      tilt_angle,
	output logic signed [bpc_pkg::OUT_W-1:0]       control_value,
	output logic [bpc_pkg::DIR_W-1:0]              drive_dir,
	output logic [bpc_pkg::DUTY_W-1:0]             drive_duty,
	output logic                                   fallen
);
	import bpc_pkg::*;

	localparam int ERR_W   = 18;
	localparam int DIFF_W  = ERR_W + 1;
	localparam int MA_W    = GAIN_W + 1;
	localparam int PROD_W  = MA_W + DIFF_W;
	localparam int GSHIFT  = 8;
	localparam int ASHIFT  = 16;
	localparam int SH_W    = PROD_W - GSHIFT;
	localparam int ACC_W   = 30;

	localparam logic signed [MA_W-1:0]   ADJ_COEF = 17'sd983;   // 0.015 in Q16
	localparam logic signed [ACC_W-1:0]  LIM      = ACC_W'(100 << FRAC_BITS);
	localparam logic signed [ACC_W-1:0]  DEAD     = ACC_W'(10 << FRAC_BITS);
	localparam logic signed [OUT_W-1:0]  BIG_OUT  = OUT_W'(5 << FRAC_BITS);
	localparam logic signed [TILT_W-1:0] CUTOFF   = TILT_W'(40 << FRAC_BITS);

	// configuration
	logic signed [SP_W-1:0]   setpoint_q;
	logic [GAIN_W-1:0]        gain_p_q;
	logic [GAIN_W-1:0]        gain_i_q;
	logic [GAIN_W-1:0]        gain_d_q;

	// working registers
	logic signed [TILT_W-1:0] tilt_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [OUT_W-1:0]  integ_q;
	logic signed [ACC_W-1:0]  acc_q;

	// controller state
	logic signed [OUT_W-1:0]  prev_out_q;
	logic signed [OUT_W-1:0]  integral_q;
	logic signed [ERR_W-1:0]  prev_err_q;
	logic                     halted_q;
	logic [DIR_W-1:0]         held_dir_q;
	logic [DUTY_W-1:0]        held_duty_q;

	logic signed [MA_W-1:0]   mul_a;
	logic signed [DIFF_W-1:0] mul_b;
	logic signed [DIFF_W-1:0] err_diff;
	logic signed [ACC_W-1:0]  prod_sh;
	logic signed [ACC_W-1:0]  integ_sum;
	logic signed [ACC_W-1:0]  integ_clamped;
	logic signed [ACC_W-1:0]  fin_sum;
	logic signed [ACC_W-1:0]  fin_clamped;
	logic signed [OUT_W-1:0]  fin_res;
	logic [OUT_W-1:0]         fin_mag;
	logic                     big_out;
	logic                     cutoff;
	logic                     halt_next;

	function automatic logic signed [ACC_W-1:0] clamp_lim(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = v;
		if (v > LIM) begin
			r = LIM;
		end else if (v < -LIM) begin
			r = -LIM;
		end
		return r;
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= '0;
			gain_p_q   <= GAIN_P_RST;
			gain_i_q   <= GAIN_I_RST;
			gain_d_q   <= GAIN_D_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SETPOINT: setpoint_q <= $signed(cfg_wdata[SP_W-1:0]);
				REG_GAIN_P:   gain_p_q   <= cfg_wdata;
				REG_GAIN_I:   gain_i_q   <= cfg_wdata;
				REG_GAIN_D:   gain_d_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// multiplier operands
	assign err_diff = $signed({err_q[ERR_W-1], err_q}) - $signed({prev_err_q[ERR_W-1], prev_err_q});

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_ADJ: begin
				mul_a = ADJ_COEF;
				mul_b = $signed({{(DIFF_W-OUT_W){prev_out_q[OUT_W-1]}}, prev_out_q});
			end
			MUL_I: begin
				mul_a = $signed({1'b0, gain_i_q});
				mul_b = $signed({err_q[ERR_W-1], err_q});
			end
			MUL_P: begin
				mul_a = $signed({1'b0, gain_p_q});
				mul_b = $signed({err_q[ERR_W-1], err_q});
			end
			MUL_D: begin
				mul_a = $signed({1'b0, gain_d_q});
				mul_b = err_diff;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// floor(product / 256), sign extended
	assign prod_sh = $signed({{(ACC_W-SH_W){prod_q[PROD_W-1]}}, prod_q[PROD_W-1:GSHIFT]});

	// integral update
	assign integ_sum = $signed({{(ACC_W-OUT_W){integral_q[OUT_W-1]}}, integral_q}) + prod_sh;
	assign integ_clamped = clamp_lim(integ_sum);

	// final sum, clamp and dead band
	assign fin_sum     = acc_q + prod_sh;
	assign fin_clamped = clamp_lim(fin_sum);
	assign halt_next   = halted_q || cutoff;

	always_comb begin
		if (halt_next || ((fin_clamped < DEAD) && (fin_clamped > -DEAD))) begin
			fin_res = '0;
		end else begin
			fin_res = fin_clamped[OUT_W-1:0];
		end
	end

	assign fin_mag = fin_res[OUT_W-1] ? OUT_W'(-fin_res) : OUT_W'(fin_res);

	assign big_out = (prev_out_q > BIG_OUT) || (prev_out_q < -BIG_OUT);
	assign cutoff  = (tilt_q > CUTOFF) || (tilt_q < -CUTOFF);

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tilt_q <= tilt_angle;
		end
		if (cmd.err_init) begin
			err_q <= $signed({{(ERR_W-TILT_W){tilt_q[TILT_W-1]}}, tilt_q})
				- $signed({{(ERR_W-SP_W){setpoint_q[SP_W-1]}}, setpoint_q});
		end else if (cmd.err_adj && big_out) begin
			err_q <= err_q + $signed(prod_q[ASHIFT+ERR_W-1:ASHIFT]);
		end
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(mul_a * mul_b);
		end
		if (cmd.integ_en) begin
			integ_q <= integ_clamped[OUT_W-1:0];
		end
		if (cmd.acc_en) begin
			acc_q <= prod_sh + $signed({{(ACC_W-OUT_W){integ_q[OUT_W-1]}}, integ_q});
		end
	end

	// controller state, committed once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_out_q  <= '0;
			integral_q  <= '0;
			prev_err_q  <= '0;
			halted_q    <= 1'b0;
			held_dir_q  <= DIR_STOP;
			held_duty_q <= '0;
		end else if (cmd.finish) begin
			prev_out_q <= fin_res;
			prev_err_q <= err_q;
			halted_q   <= halt_next;
			integral_q <= halt_next ? '0 : integ_q;
			if (halt_next) begin
				held_dir_q  <= DIR_STOP;
				held_duty_q <= '0;
			end else if (fin_res != '0) begin
				held_dir_q  <= fin_res[OUT_W-1] ? DIR_NEG : DIR_POS;
				held_duty_q <= fin_mag[FRAC_BITS+DUTY_W-1:FRAC_BITS];
			end
		end
	end

	// result word is the committed state
	assign control_value = prev_out_q;
	assign drive_dir     = held_dir_q;
	assign drive_duty    = held_duty_q;
	assign fallen        = halted_q;

	`BPC_ASSERT_ALWAYS(a_integ_in_range, (integral_q <= OUT_W'(LIM)) && (integral_q >= -OUT_W'(LIM)))
	`BPC_ASSERT_IMP(a_halt_zeroes, halted_q, (prev_out_q == '0) && (integral_q == '0) && (held_dir_q == DIR_STOP) && (held_duty_q == '0))
	`BPC_ASSERT_NEXT(a_halt_latches, halted_q, halted_q)
	`BPC_ASSERT_IMP(a_pos_drive, prev_out_q > 0, (held_dir_q == DIR_POS) && (held_duty_q == prev_out_q[FRAC_BITS+DUTY_W-1:FRAC_BITS]))

endmodule

@@ sv/balance_pid_with_cutoff_unit.sv @@
// ----------------------------------------------------------------------------
// balance_pid_with_cutoff_unit
// PID balance controller with integral clamp, dead band and tilt cutoff.
// One tilt sample word in on the input channel, one result word out: the
// clamped output, motor direction, integer duty and the halt flag.
// The configuration port writes setpoint and gains; write it while idle.
// The sequencer issues four products through one shared 17 x 19
// multiplier, each registered before use, and takes a new sample only
// after the last one is committed.
// Reset clears the controller state and halt, loads default gains and
// leaves no result pending. While out_stall holds the pending result, the
// block still takes the next sample and runs it up to the final step,
// where it waits until the result register is free.
// Once the tilt exceeds the cutoff, the halt holds until reset.
// ----------------------------------------------------------------------------
module balance_pid_with_cutoff_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bpc_pkg::IDX_W-1:0]         cfg_idx,
	input  logic [bpc_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [bpc_pkg::TILT_W-1:0] tilt_angle,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [bpc_pkg::OUT_W-1:0]  control_value,
	output logic [bpc_pkg::DIR_W-1:0]         drive_dir,
	output logic [bpc_pkg::DUTY_W-1:0]        drive_duty,
	output logic                              fallen
);
	import bpc_pkg::*;

	bpc_cmd_t cmd;

	// sequencer
	bpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// datapath
	bpc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.tilt_angle    (tilt_angle),
		.control_value (control_value),
		.drive_dir     (drive_dir),
		.drive_duty    (drive_duty),
		.fallen        (fallen)
	);

endmodule
